// ----- sv/wsdf_pkg.sv -----
// Shared types and constants for the WebSocket frame deframer.
package wsdf_pkg;

    // Parser position within a frame
    typedef enum logic [2:0] {
        PH_HDR0    = 3'd0,
        PH_HDR1    = 3'd1,
        PH_EXT16   = 3'd2,
        PH_EXT64   = 3'd3,
        PH_KEY     = 3'd4,
        PH_PAYLOAD = 3'd5,
        PH_ERROR   = 3'd6
    } phase_t;

    // Result kind carried on tuser
    typedef enum logic [1:0] {
        KIND_HEADER  = 2'd0,
        KIND_PAYLOAD = 2'd1,
        KIND_ERROR   = 2'd2
    } kind_t;

    // Seven-bit length codes that announce an extended length
    localparam logic [6:0] LEN_CODE_EXT16 = 7'd126;
    localparam logic [6:0] LEN_CODE_EXT64 = 7'd127;

    localparam int unsigned LEN_W   = 32;
    localparam int unsigned TDATA_W = 56;

    // One result transfer
    typedef struct packed {
        kind_t             kind;
        logic              fin_flag;
        logic [2:0]        reserved_bits;
        logic [3:0]        frame_opcode;
        logic              mask_flag;
        logic [LEN_W-1:0]  payload_length;
        logic [7:0]        payload_byte;
        logic              last;
    } result_t;

endpackage

// ----- sv/websocket_frame_deframer_core.sv -----
// WebSocket frame deframer: byte-stream header parser and payload unmasker.
//
//  channel | dir | tdata / tuser / tlast
//  --------+-----+-------------------------------------------------------------
//  s_      | in  | tdata[7:0] stream byte
//  m_      | out | tdata: fin, rsv[3], opcode[4], mask, length[32], byte[8];
//          |     | tuser: kind; tlast: final result of a frame
//
//  One byte per cycle while m_tready holds no result back: a byte is held in an
//  input register and parsed by the per-byte state machine and unmask XOR into
//  the result register. The input register takes a new byte while a result
//  waits only when it is empty.
//  Reset (aresetn low, synchronous) returns the parser to the first header
//  byte; a parse error is sticky and swallows all later bytes until reset.
module websocket_frame_deframer_core (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_tvalid,
    output logic                         s_tready,
    input  logic [7:0]                   s_tdata,   // [7:0] stream_byte
    output logic                         m_tvalid,
    input  logic                         m_tready,
    // [0] fin_flag, [3:1] reserved_bits, [7:4] frame_opcode, [8] mask_flag,
    // [40:9] payload_length, [48:41] payload_byte, [55:49] zero
    output logic [wsdf_pkg::TDATA_W-1:0] m_tdata,
    output logic [1:0]                   m_tuser,   // [1:0] kind
    output logic                         m_tlast
);

    // Input register
    logic        in_valid_reg;
    logic [7:0]  in_byte_reg;

    // Parser state
    wsdf_pkg::phase_t phase_reg, phase_next;
    logic        fin_reg, fin_next;
    logic [2:0]  rsv_reg, rsv_next;
    logic [3:0]  opcode_reg, opcode_next;
    logic        masked_reg, masked_next;
    logic [31:0] length_reg, length_next;
    logic [2:0]  fcount_reg, fcount_next;
    logic [31:0] key_reg, key_next;
    logic [31:0] pcount_reg, pcount_next;

    // Result register
    logic              out_valid_reg;
    wsdf_pkg::result_t out_reg;
    logic              res_valid;
    wsdf_pkg::result_t res;

    logic        advance;
    logic [7:0]  b;
    logic [6:0]  len7;
    logic [31:0] ext16_len;
    logic [31:0] ext64_len;
    logic [31:0] pcount_inc;
    logic [2:0]  fcount_inc;
    logic [7:0]  key_byte;

    // Move a byte from the input register when the result slot is free
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    assign b          = in_byte_reg;
    assign len7       = b[6:0];
    assign ext16_len  = {16'd0, length_reg[7:0], b};
    assign ext64_len  = {length_reg[23:0], b};
    assign pcount_inc = pcount_reg + 32'd1;
    assign fcount_inc = fcount_reg + 3'd1;

    // Pick the key byte for this payload position, first key byte at index 0
    always_comb begin
        case (pcount_reg[1:0])
            2'd0:    key_byte = key_reg[31:24];
            2'd1:    key_byte = key_reg[23:16];
            2'd2:    key_byte = key_reg[15:8];
            default: key_byte = key_reg[7:0];
        endcase
    end

    // Next parser state
    always_comb begin
        phase_next  = phase_reg;
        fin_next    = fin_reg;
        rsv_next    = rsv_reg;
        opcode_next = opcode_reg;
        masked_next = masked_reg;
        length_next = length_reg;
        fcount_next = fcount_reg;
        key_next    = key_reg;
        pcount_next = pcount_reg;
        case (phase_reg)
            wsdf_pkg::PH_HDR1: begin
                masked_next = b[7];
                fcount_next = 3'd0;
                if (len7 == wsdf_pkg::LEN_CODE_EXT16) begin
                    length_next = 32'd0;
                    phase_next  = wsdf_pkg::PH_EXT16;
                end else if (len7 == wsdf_pkg::LEN_CODE_EXT64) begin
                    length_next = 32'd0;
                    phase_next  = wsdf_pkg::PH_EXT64;
                end else begin
                    length_next = {25'd0, len7};
                    if (b[7]) begin
                        key_next   = 32'd0;
                        phase_next = wsdf_pkg::PH_KEY;
                    end else begin
                        pcount_next = 32'd0;
                        phase_next  = (len7 == 7'd0) ? wsdf_pkg::PH_HDR0
                                                     : wsdf_pkg::PH_PAYLOAD;
                    end
                end
            end
            wsdf_pkg::PH_EXT16: begin
                length_next = ext16_len;
                fcount_next = fcount_inc;
                if (fcount_inc == 3'd2) begin
                    fcount_next = 3'd0;
                    if (masked_reg) begin
                        key_next   = 32'd0;
                        phase_next = wsdf_pkg::PH_KEY;
                    end else begin
                        pcount_next = 32'd0;
                        phase_next  = (ext16_len == 32'd0) ? wsdf_pkg::PH_HDR0
                                                           : wsdf_pkg::PH_PAYLOAD;
                    end
                end
            end
            wsdf_pkg::PH_EXT64: begin
                // Upper half must be zero; lower half forms the length
                if (!fcount_reg[2]) begin
                    if (b != 8'd0) begin
                        phase_next = wsdf_pkg::PH_ERROR;
                    end else begin
                        fcount_next = fcount_inc;
                    end
                end else begin
                    length_next = ext64_len;
                    fcount_next = fcount_inc;
                    if (fcount_inc == 3'd0) begin
                        if (masked_reg) begin
                            key_next   = 32'd0;
                            phase_next = wsdf_pkg::PH_KEY;
                        end else begin
                            pcount_next = 32'd0;
                            phase_next  = (ext64_len == 32'd0) ? wsdf_pkg::PH_HDR0
                                                               : wsdf_pkg::PH_PAYLOAD;
                        end
                    end
                end
            end
            wsdf_pkg::PH_KEY: begin
                key_next    = {key_reg[23:0], b};
                fcount_next = fcount_inc;
                if (fcount_inc == 3'd4) begin
                    pcount_next = 32'd0;
                    phase_next  = (length_reg == 32'd0) ? wsdf_pkg::PH_HDR0
                                                        : wsdf_pkg::PH_PAYLOAD;
                end
            end
            wsdf_pkg::PH_PAYLOAD: begin
                pcount_next = pcount_inc;
                if (pcount_inc == length_reg) begin
                    phase_next = wsdf_pkg::PH_HDR0;
                end
            end
            wsdf_pkg::PH_ERROR: begin
                phase_next = wsdf_pkg::PH_ERROR;
            end
            default: begin
                fin_next    = b[7];
                rsv_next    = b[6:4];
                opcode_next = b[3:0];
                phase_next  = wsdf_pkg::PH_HDR1;
            end
        endcase
    end

    // Result for the byte in the input register
    always_comb begin
        res_valid          = 1'b0;
        res.kind           = wsdf_pkg::KIND_HEADER;
        res.fin_flag       = fin_reg;
        res.reserved_bits  = rsv_reg;
        res.frame_opcode   = opcode_reg;
        res.mask_flag      = masked_next;
        res.payload_length = 32'd0;
        res.payload_byte   = 8'd0;
        res.last           = 1'b0;
        case (phase_reg)
            wsdf_pkg::PH_HDR1: begin
                if (len7 != wsdf_pkg::LEN_CODE_EXT16 && len7 != wsdf_pkg::LEN_CODE_EXT64
                        && !b[7]) begin
                    res_valid          = 1'b1;
                    res.payload_length = {25'd0, len7};
                    res.last           = (len7 == 7'd0);
                end
            end
            wsdf_pkg::PH_EXT16: begin
                if (fcount_inc == 3'd2 && !masked_reg) begin
                    res_valid          = 1'b1;
                    res.payload_length = ext16_len;
                    res.last           = (ext16_len == 32'd0);
                end
            end
            wsdf_pkg::PH_EXT64: begin
                if (!fcount_reg[2]) begin
                    if (b != 8'd0) begin
                        res_valid = 1'b1;
                        res.kind  = wsdf_pkg::KIND_ERROR;
                        res.last  = 1'b1;
                    end
                end else if (fcount_inc == 3'd0 && !masked_reg) begin
                    res_valid          = 1'b1;
                    res.payload_length = ext64_len;
                    res.last           = (ext64_len == 32'd0);
                end
            end
            wsdf_pkg::PH_KEY: begin
                if (fcount_inc == 3'd4) begin
                    res_valid          = 1'b1;
                    res.payload_length = length_reg;
                    res.last           = (length_reg == 32'd0);
                end
            end
            wsdf_pkg::PH_PAYLOAD: begin
                res_valid          = 1'b1;
                res.kind           = wsdf_pkg::KIND_PAYLOAD;
                res.payload_length = length_reg;
                res.payload_byte   = masked_reg ? (b ^ key_byte) : b;
                res.last           = (pcount_inc == length_reg);
            end
            default: begin
                res_valid = 1'b0;
            end
        endcase
    end

    // Input register: take a transfer whenever it is empty or draining
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
        if (s_tready) begin
            in_byte_reg <= s_tdata;
        end
    end

    // Parser state: advance once per consumed byte
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg  <= wsdf_pkg::PH_HDR0;
            fin_reg    <= 1'b0;
            rsv_reg    <= 3'd0;
            opcode_reg <= 4'd0;
            masked_reg <= 1'b0;
            length_reg <= 32'd0;
            fcount_reg <= 3'd0;
            key_reg    <= 32'd0;
            pcount_reg <= 32'd0;
        end else if (advance) begin
            phase_reg  <= phase_next;
            fin_reg    <= fin_next;
            rsv_reg    <= rsv_next;
            opcode_reg <= opcode_next;
            masked_reg <= masked_next;
            length_reg <= length_next;
            fcount_reg <= fcount_next;
            key_reg    <= key_next;
            pcount_reg <= pcount_next;
        end
    end

    // Result register: load on advance, drop once the transfer completes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= res_valid;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
        if (advance) begin
            out_reg <= res;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_reg.kind;
    assign m_tlast  = out_reg.last;
    assign m_tdata  = {7'd0, out_reg.payload_byte, out_reg.payload_length,
                       out_reg.mask_flag, out_reg.frame_opcode,
                       out_reg.reserved_bits, out_reg.fin_flag};

endmodule
